/* hw/rtl/fkv_pkg.sv */
// Shared constants, payload types and helper functions of the flash key/value log store.
`timescale 1ns / 1ps

package fkv_pkg;

   localparam int PAGE_BYTES       = 1024;
   localparam int PAGE_HW          = PAGE_BYTES / 2;
   localparam int MAX_BUCKETS      = 4;
   localparam int MAX_BUCKET_PAGES = 2;
   localparam int MAX_KEY_BYTES    = 8;
   localparam int MAX_DATA_BYTES   = 8;
   localparam int HEADER_BYTES     = 4;
   localparam int HDR_HW           = (HEADER_BYTES + 1) / 2;
   localparam int STORE_DEPTH      = MAX_BUCKETS * MAX_BUCKET_PAGES * PAGE_HW;
   localparam int ADDR_W           = $clog2(STORE_DEPTH);
   localparam int OFF_W            = $clog2(MAX_BUCKET_PAGES * PAGE_HW + 1);
   localparam int BKT_W            = $clog2(MAX_BUCKETS);
   localparam int CNT_W            = 3;
   localparam int LEN_W            = 9;
   localparam int HW_W             = 16;

   localparam logic [1:0] ACT_FORMAT = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_NEXT   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_SMALL = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [3:0]  key_size;
      logic [63:0] data;
      logic [3:0]  data_size;
      logic [9:0]  handle;
      logic        handle_valid;
   } fkv_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] out_key;
      logic [3:0]  out_key_size;
      logic [63:0] out_data;
      logic [3:0]  out_data_size;
      logic [9:0]  next_handle;
      logic        at_end;
   } fkv_rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] bucket_count;
      logic [1:0]       bucket_pages;
   } fkv_cfg_type;

   // Halfwords taken by a record, from its header halfword.
   function automatic logic [LEN_W-1:0] fkv_rec_len(input logic [15:0] hdr);
      logic [LEN_W-1:0] kw;
      logic [LEN_W-1:0] dw;
      kw = ({1'b0, hdr[7:0]} + 9'd1) >> 1;
      dw = ({1'b0, hdr[15:8]} + 9'd1) >> 1;
      return 9'd1 + kw + dw;
   endfunction

   function automatic logic [63:0] fkv_byte_mask(input logic [3:0] n);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

/* hw/rtl/fkv_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module fkv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/fkv_engine.sv */
// Sequencer that walks, compacts and appends records through one memory port and one address adder.
`timescale 1ns / 1ps

module fkv_engine import fkv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  fkv_cfg_type       cfg,
   input  logic              cfg_wr,
   input  logic              start,
   input  fkv_req_type       req,
   output logic              idle,
   output logic              done,
   output fkv_rsp_type       rsp,
   input  logic              rsp_take,
   output logic              ram_we,
   output logic [ADDR_W-1:0] ram_addr,
   output logic [HW_W-1:0]   ram_wdata,
   input  logic [HW_W-1:0]   ram_rdata
);

   typedef enum logic [5:0] {
      S_IDLE, S_FMT, S_F_HDR, S_F_HDRW, S_F_WRD, S_F_WRW,
      S_W_FIT, S_W_ALLOC, S_W_STORE, S_W_REFIT,
      S_C_START, S_C_SRC, S_C_SRC_DONE, S_C_DUP, S_C_DUP_DONE, S_C_PLACE,
      S_C_CP_RD, S_C_CP_WR, S_C_NEXT, S_C_END,
      S_R_LOOP, S_R_CHECK,
      S_N_HSCAN, S_N_HSTEP, S_N_OUTER, S_N_CAND, S_N_DUP, S_N_DUP_DONE,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {FM_HDR, FM_KEY, FM_ALL} fetch_mode_type;

   state_type      state_ff, state_in, ret_ff, ret_in;
   fetch_mode_type f_mode_ff, f_mode_in;
   logic [BKT_W-1:0] active_ff, active_in, nb_ff, nb_in, f_bkt_ff, f_bkt_in;
   logic [OFF_W-1:0] top_ff, top_in, src_ff, src_in, scan_ff, scan_in, dtop_ff, dtop_in;
   logic [OFF_W-1:0] f_off_ff, f_off_in;
   logic [LEN_W-1:0] f_cnt_ff, f_cnt_in, f_nwt_ff, f_nwt_in, cp_cnt_ff, cp_cnt_in;
   logic [7:0]       f_nkw_ff, f_nkw_in;
   logic [3:0]       ks_ff, ks_in, ds_ff, ds_in, dsz_ff, dsz_in, wcnt_ff, wcnt_in;
   logic [63:0]      key_ff, key_in, data_ff, data_in;
   logic [9:0]       handle_ff, handle_in;
   logic [15:0]      hdr_ff, hdr_in, c_hdr_ff, c_hdr_in;
   logic [63:0]      kv_ff, kv_in, dv_ff, dv_in, c_kv_ff, c_kv_in, c_dv_ff, c_dv_in;
   fkv_rsp_type      res_ff, res_in;

   logic [1:0]       pages_eff;
   logic [CNT_W-1:0] cnt_eff, nb_sum;
   logic [OFF_W-1:0] bhw;
   logic [2:0]       nkw, ndw;
   logic [3:0]       need, req_ks, req_ds;
   logic [LEN_W-1:0] hdr_len, c_len, hk, hd, widx;
   logic             key_hit, cand_hit;
   logic [BKT_W-1:0] sel_bkt;
   logic [OFF_W-1:0] sel_off;
   logic [1:0]       kidx, didx;

   // Effective geometry from the configuration registers.
   always_comb begin
      if (cfg.bucket_pages == 2'd0) begin
         pages_eff = 2'd1;
      end else if (cfg.bucket_pages > 2'(MAX_BUCKET_PAGES)) begin
         pages_eff = 2'(MAX_BUCKET_PAGES);
      end else begin
         pages_eff = cfg.bucket_pages;
      end
      if (cfg.bucket_count < CNT_W'(2)) begin
         cnt_eff = CNT_W'(2);
      end else if (cfg.bucket_count > CNT_W'(MAX_BUCKETS)) begin
         cnt_eff = CNT_W'(MAX_BUCKETS);
      end else begin
         cnt_eff = cfg.bucket_count;
      end
   end

   assign bhw      = OFF_W'(OFF_W'(pages_eff) * OFF_W'(PAGE_HW));
   assign nb_sum   = CNT_W'(active_ff) + CNT_W'(1);
   assign nkw      = 3'(({1'b0, ks_ff} + 5'd1) >> 1);
   assign ndw      = 3'(({1'b0, ds_ff} + 5'd1) >> 1);
   assign need     = 4'd1 + 4'(nkw) + 4'(ndw);
   assign hdr_len  = fkv_rec_len(hdr_ff);
   assign c_len    = fkv_rec_len(c_hdr_ff);
   assign hk       = ({1'b0, ram_rdata[7:0]} + 9'd1) >> 1;
   assign hd       = ({1'b0, ram_rdata[15:8]} + 9'd1) >> 1;
   assign key_hit  = (hdr_ff[7:0] == 8'(ks_ff)) && (kv_ff == key_ff);
   assign cand_hit = (hdr_ff[7:0] == c_hdr_ff[7:0]) && (kv_ff == c_kv_ff);
   assign widx     = f_cnt_ff - 9'(f_nkw_ff);

   assign req_ks = (req.key_size == 4'd0) ? 4'd1 :
                   (req.key_size > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : req.key_size;
   assign req_ds = (req.data_size > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : req.data_size;

   // The one address adder: bucket base plus halfword offset.
   always_comb begin
      sel_bkt = f_bkt_ff;
      sel_off = f_off_ff;
      case (state_ff)
         S_F_WRD: begin
            sel_off = OFF_W'(f_off_ff + OFF_W'(1) + OFF_W'(f_cnt_ff));
         end
         S_C_CP_RD: begin
            sel_bkt = active_ff;
            sel_off = OFF_W'(src_ff + OFF_W'(cp_cnt_ff));
         end
         S_C_CP_WR: begin
            sel_bkt = nb_ff;
            sel_off = OFF_W'(dtop_ff + OFF_W'(cp_cnt_ff));
         end
         S_W_STORE: begin
            sel_bkt = active_ff;
            sel_off = OFF_W'(top_ff + OFF_W'(wcnt_ff));
         end
         default: begin
         end
      endcase
      ram_addr = ADDR_W'(ADDR_W'(sel_bkt) * ADDR_W'(bhw)) + ADDR_W'(sel_off);
   end

   assign kidx = 2'(wcnt_ff - 4'd1);
   assign didx = 2'(wcnt_ff - 4'd1 - 4'(nkw));

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = ram_rdata;
      if (state_ff == S_W_STORE) begin
         ram_we = 1'b1;
         if (wcnt_ff == 4'd0) begin
            ram_wdata = {4'd0, ds_ff, 4'd0, ks_ff};
         end else if (wcnt_ff <= 4'(nkw)) begin
            ram_wdata = key_ff[{kidx, 4'd0} +: 16];
         end else begin
            ram_wdata = data_ff[{didx, 4'd0} +: 16];
         end
      end else if (state_ff == S_C_CP_WR) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      f_mode_in = f_mode_ff;
      active_in = active_ff;
      nb_in     = nb_ff;
      f_bkt_in  = f_bkt_ff;
      top_in    = top_ff;
      src_in    = src_ff;
      scan_in   = scan_ff;
      dtop_in   = dtop_ff;
      f_off_in  = f_off_ff;
      f_cnt_in  = f_cnt_ff;
      f_nwt_in  = f_nwt_ff;
      f_nkw_in  = f_nkw_ff;
      cp_cnt_in = cp_cnt_ff;
      ks_in     = ks_ff;
      ds_in     = ds_ff;
      dsz_in    = dsz_ff;
      wcnt_in   = wcnt_ff;
      key_in    = key_ff;
      data_in   = data_ff;
      handle_in = handle_ff;
      hdr_in    = hdr_ff;
      c_hdr_in  = c_hdr_ff;
      kv_in     = kv_ff;
      dv_in     = dv_ff;
      c_kv_in   = c_kv_ff;
      c_dv_in   = c_dv_ff;
      res_in    = res_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ks_in     = req_ks;
               ds_in     = req_ds;
               dsz_in    = req.data_size;
               key_in    = req.key & fkv_byte_mask(req_ks);
               data_in   = req.data & fkv_byte_mask(req_ds);
               handle_in = req.handle;
               res_in    = '0;
               case (req.action)
                  ACT_FORMAT: begin
                     active_in = '0;
                     top_in    = bhw;
                     state_in  = S_DONE;
                  end
                  ACT_WRITE: begin
                     state_in = S_W_FIT;
                  end
                  ACT_READ: begin
                     src_in   = top_ff;
                     state_in = S_R_LOOP;
                  end
                  default: begin
                     src_in   = top_ff;
                     scan_in  = top_ff;
                     state_in = req.handle_valid ? S_N_HSCAN : S_N_OUTER;
                  end
               endcase
            end
         end

         S_FMT: begin
            active_in = '0;
            top_in    = bhw;
            state_in  = S_IDLE;
         end

         // Record fetch: the header, then the key halfwords, or the key and data halfwords, as the mode asks.
         S_F_HDR: begin
            state_in = S_F_HDRW;
         end
         S_F_HDRW: begin
            hdr_in   = ram_rdata;
            kv_in    = '0;
            dv_in    = '0;
            f_cnt_in = '0;
            f_nkw_in = 8'(hk);
            case (f_mode_ff)
               FM_HDR:  f_nwt_in = '0;
               FM_KEY:  f_nwt_in = hk;
               default: f_nwt_in = LEN_W'(hk + hd);
            endcase
            if (f_mode_ff == FM_HDR || (f_mode_ff == FM_KEY && hk == '0)) begin
               state_in = ret_ff;
            end else begin
               state_in = S_F_WRD;
            end
         end
         S_F_WRD: begin
            state_in = S_F_WRW;
         end
         S_F_WRW: begin
            if (f_cnt_ff < 9'(f_nkw_ff)) begin
               if (f_cnt_ff < 9'd4) begin
                  kv_in[{f_cnt_ff[1:0], 4'd0} +: 16] = ram_rdata;
               end
            end else if (widx < 9'd4) begin
               dv_in[{widx[1:0], 4'd0} +: 16] = ram_rdata;
            end
            f_cnt_in = f_cnt_ff + 9'd1;
            state_in = (f_cnt_ff + 9'd1 == f_nwt_ff) ? ret_ff : S_F_WRD;
         end

         // Append.
         S_W_FIT: begin
            state_in = (top_ff < OFF_W'(HDR_HW) + OFF_W'(need)) ? S_C_START : S_W_ALLOC;
         end
         S_W_REFIT: begin
            if (top_ff < OFF_W'(HDR_HW) + OFF_W'(need)) begin
               res_in.status = ST_FULL;
               state_in      = S_DONE;
            end else begin
               state_in = S_W_ALLOC;
            end
         end
         S_W_ALLOC: begin
            top_in   = top_ff - OFF_W'(need);
            wcnt_in  = '0;
            state_in = S_W_STORE;
         end
         S_W_STORE: begin
            wcnt_in = wcnt_ff + 4'd1;
            if (wcnt_ff + 4'd1 == need) begin
               res_in.status = ST_OK;
               state_in      = S_DONE;
            end
         end

         // Compaction into the next bucket of the ring.
         S_C_START: begin
            nb_in    = (nb_sum >= cnt_eff) ? '0 : BKT_W'(nb_sum);
            src_in   = top_ff;
            dtop_in  = bhw;
            state_in = S_C_SRC;
         end
         S_C_SRC: begin
            if (src_ff >= bhw) begin
               state_in = S_C_END;
            end else begin
               f_bkt_in  = active_ff;
               f_off_in  = src_ff;
               f_mode_in = FM_KEY;
               ret_in    = S_C_SRC_DONE;
               state_in  = S_F_HDR;
            end
         end
         S_C_SRC_DONE: begin
            c_hdr_in = hdr_ff;
            c_kv_in  = kv_ff;
            scan_in  = dtop_ff;
            state_in = key_hit ? S_C_NEXT : S_C_DUP;
         end
         S_C_DUP: begin
            if (scan_ff >= bhw) begin
               state_in = S_C_PLACE;
            end else begin
               f_bkt_in  = nb_ff;
               f_off_in  = scan_ff;
               f_mode_in = FM_KEY;
               ret_in    = S_C_DUP_DONE;
               state_in  = S_F_HDR;
            end
         end
         S_C_DUP_DONE: begin
            if (cand_hit) begin
               state_in = S_C_NEXT;
            end else begin
               scan_in  = OFF_W'(scan_ff + OFF_W'(hdr_len));
               state_in = S_C_DUP;
            end
         end
         S_C_PLACE: begin
            if (dtop_ff >= OFF_W'(HDR_HW) + OFF_W'(c_len)) begin
               dtop_in   = dtop_ff - OFF_W'(c_len);
               cp_cnt_in = '0;
               state_in  = S_C_CP_RD;
            end else begin
               state_in = S_C_NEXT;
            end
         end
         S_C_CP_RD: begin
            state_in = S_C_CP_WR;
         end
         S_C_CP_WR: begin
            cp_cnt_in = cp_cnt_ff + 9'd1;
            state_in  = (cp_cnt_ff + 9'd1 == c_len) ? S_C_NEXT : S_C_CP_RD;
         end
         S_C_NEXT: begin
            src_in   = OFF_W'(src_ff + OFF_W'(c_len));
            state_in = S_C_SRC;
         end
         S_C_END: begin
            active_in = nb_ff;
            top_in    = dtop_ff;
            state_in  = S_W_REFIT;
         end

         // Lookup of the newest record with the key.
         S_R_LOOP: begin
            if (src_ff >= bhw) begin
               res_in.status = ST_MISS;
               state_in      = S_DONE;
            end else begin
               f_bkt_in  = active_ff;
               f_off_in  = src_ff;
               f_mode_in = FM_ALL;
               ret_in    = S_R_CHECK;
               state_in  = S_F_HDR;
            end
         end
         S_R_CHECK: begin
            if (key_hit) begin
               res_in.out_data_size = hdr_ff[11:8];
               if ({4'd0, dsz_ff} < hdr_ff[15:8]) begin
                  res_in.status = ST_SMALL;
               end else begin
                  res_in.status   = ST_OK;
                  res_in.out_data = dv_ff;
               end
               state_in = S_DONE;
            end else begin
               src_in   = OFF_W'(src_ff + OFF_W'(hdr_len));
               state_in = S_R_LOOP;
            end
         end

         // Iteration over distinct keys.
         S_N_HSCAN: begin
            if (scan_ff >= bhw) begin
               res_in.status = ST_MISS;
               res_in.at_end = 1'b1;
               state_in      = S_DONE;
            end else begin
               f_bkt_in  = active_ff;
               f_off_in  = scan_ff;
               f_mode_in = FM_HDR;
               ret_in    = S_N_HSTEP;
               state_in  = S_F_HDR;
            end
         end
         S_N_HSTEP: begin
            if (scan_ff == OFF_W'(handle_ff)) begin
               src_in   = OFF_W'(scan_ff + OFF_W'(hdr_len));
               state_in = S_N_OUTER;
            end else begin
               scan_in  = OFF_W'(scan_ff + OFF_W'(hdr_len));
               state_in = S_N_HSCAN;
            end
         end
         S_N_OUTER: begin
            if (src_ff >= bhw) begin
               res_in.status = ST_MISS;
               res_in.at_end = 1'b1;
               state_in      = S_DONE;
            end else begin
               f_bkt_in  = active_ff;
               f_off_in  = src_ff;
               f_mode_in = FM_ALL;
               ret_in    = S_N_CAND;
               state_in  = S_F_HDR;
            end
         end
         S_N_CAND: begin
            c_hdr_in = hdr_ff;
            c_kv_in  = kv_ff;
            c_dv_in  = dv_ff;
            scan_in  = top_ff;
            state_in = S_N_DUP;
         end
         S_N_DUP: begin
            if (scan_ff >= src_ff) begin
               res_in.status        = ST_OK;
               res_in.out_key       = c_kv_ff;
               res_in.out_key_size  = c_hdr_ff[3:0];
               res_in.out_data      = c_dv_ff;
               res_in.out_data_size = c_hdr_ff[11:8];
               res_in.next_handle   = src_ff[9:0];
               state_in             = S_DONE;
            end else begin
               f_bkt_in  = active_ff;
               f_off_in  = scan_ff;
               f_mode_in = FM_KEY;
               ret_in    = S_N_DUP_DONE;
               state_in  = S_F_HDR;
            end
         end
         S_N_DUP_DONE: begin
            if (cand_hit) begin
               src_in   = OFF_W'(src_ff + OFF_W'(c_len));
               state_in = S_N_OUTER;
            end else begin
               scan_in  = OFF_W'(scan_ff + OFF_W'(hdr_len));
               state_in = S_N_DUP;
            end
         end

         S_DONE: begin
            if (rsp_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr) begin
         state_in = S_FMT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
         top_ff    <= OFF_W'(PAGE_HW);
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         top_ff    <= top_in;
      end
      ret_ff    <= ret_in;
      f_mode_ff <= f_mode_in;
      nb_ff     <= nb_in;
      f_bkt_ff  <= f_bkt_in;
      src_ff    <= src_in;
      scan_ff   <= scan_in;
      dtop_ff   <= dtop_in;
      f_off_ff  <= f_off_in;
      f_cnt_ff  <= f_cnt_in;
      f_nwt_ff  <= f_nwt_in;
      f_nkw_ff  <= f_nkw_in;
      cp_cnt_ff <= cp_cnt_in;
      ks_ff     <= ks_in;
      ds_ff     <= ds_in;
      dsz_ff    <= dsz_in;
      wcnt_ff   <= wcnt_in;
      key_ff    <= key_in;
      data_ff   <= data_in;
      handle_ff <= handle_in;
      hdr_ff    <= hdr_in;
      c_hdr_ff  <= c_hdr_in;
      kv_ff     <= kv_in;
      dv_ff     <= dv_in;
      c_kv_ff   <= c_kv_in;
      c_dv_ff   <= c_dv_in;
      res_ff    <= res_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE);
   assign rsp  = res_ff;

   // The log top never runs past the bucket end, except while a new geometry settles.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FMT) |-> (top_ff <= bhw))
      else $error("log top beyond bucket end");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FMT) |-> (CNT_W'(active_ff) < cnt_eff))
      else $error("active bucket outside the ring");

   // Appends never land in the reserved bucket header.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_W_STORE) |-> (top_ff >= OFF_W'(HDR_HW)))
      else $error("record written into bucket header");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_take && !cfg_wr) |=> (state_ff == S_IDLE))
      else $error("result handed over but sequencer not idle");

endmodule

/* hw/rtl/flash_key_value_log_store.sv */
// Top level of the flash key/value log store: channels, register port, result register.
`timescale 1ns / 1ps

//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_data  (fkv_req_type)
//  rsp       out        rsp_valid/rsp_stall   rsp_data  (fkv_rsp_type)
//  csr       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One item is worked on at a time. Every record visited passes through the step
// that picks it, its header read, the header capture and the check, plus a read
// and a capture for each key (and data) halfword fetched through the single
// memory port, so read and next grow with the log depth, next quadratically since
// each candidate is checked against all newer records.
// A write that overflows compacts the bucket: each live record is checked against
// the records already moved and then copied halfword by halfword, read then written.
// Reset is synchronous; it restores 2 buckets of 1 page and an empty log in bucket 0.
// The result sits in an output register, so the next item is taken while it waits.
module flash_key_value_log_store import fkv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fkv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fkv_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Register select bit of the byte address (registers sit 4 bytes apart).
   localparam logic REG_BUCKET_COUNT = 1'b0;
   localparam logic REG_BUCKET_PAGES = 1'b1;

   fkv_cfg_type       cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fkv_rsp_type       rsp_ff, rsp_in;
   logic              cfg_we, start, eng_idle, eng_done, take;
   fkv_rsp_type       eng_rsp;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [HW_W-1:0]   ram_wdata, ram_rdata;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite;

   // Any register write reformats the store, so items are held off in that cycle.
   assign req_stall = !eng_idle || cfg_we;
   assign start     = req_valid && !req_stall;

   // The engine hands over its result once the output register is free or draining.
   assign take = eng_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         if (paddr[2] == REG_BUCKET_PAGES) begin
            cfg_in.bucket_pages = pwdata[1:0];
         end else begin
            cfg_in.bucket_count = pwdata[CNT_W-1:0];
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_BUCKET_COUNT: prdata = {{(32 - CNT_W){1'b0}}, cfg_ff.bucket_count};
         default:          prdata = {30'd0, cfg_ff.bucket_pages};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_count <= CNT_W'(2);
         cfg_ff.bucket_pages <= 2'd1;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   fkv_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_wr    (cfg_we),
      .start     (start),
      .req       (req_data),
      .idle      (eng_idle),
      .done      (eng_done),
      .rsp       (eng_rsp),
      .rsp_take  (take),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // Halfword store; only the live log of a bucket is ever read back, so it
   // needs no clearing after reset or format.
   fkv_ram #(
      .WIDTH (HW_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

/* verif/tb_flash_key_value_log_store.sv */
// Testbench of the flash key/value log store: directed table, random traffic, self-check.
`timescale 1ns / 1ps

// The testbench keeps its own image of the halfword store and walks the same record
// log as the block does. Every accepted item is run through that image to work out
// the result it must produce. Results are checked in order, field by field. The
// configuration registers are written only while the block has no item in flight.
module tb_flash_key_value_log_store;
   import fkv_pkg::*;

   // Byte addresses of the two registers on the configuration port.
   localparam logic [2:0] REG_BUCKET_COUNT = 3'd0;
   localparam logic [2:0] REG_BUCKET_PAGES = 3'd4;
   localparam int         KEY_POOL         = 80;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   fkv_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fkv_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   flash_key_value_log_store i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 4 ns clock.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the store. The bucket marks never reach an output, so only
   // the halfwords, the active bucket and the log top are kept.
   // ------------------------------------------------------------------
   logic [15:0]  flash_img [STORE_DEPTH];
   int unsigned  act_bkt;
   int unsigned  log_top;
   int unsigned  cfg_count;
   int unsigned  cfg_pages;

   fkv_rsp_type  pending_rsp[$];
   int           fail_count;
   logic [9:0]   last_handle;
   logic [63:0]  key_pool [KEY_POOL];
   logic [3:0]   key_len_pool [KEY_POOL];

   function automatic int unsigned ring_size();
      int unsigned c;
      c = cfg_count;
      if (c < 2) c = 2;
      if (c > MAX_BUCKETS) c = MAX_BUCKETS;
      return c;
   endfunction

   function automatic int unsigned bucket_len();
      int unsigned p;
      p = cfg_pages;
      if (p < 1) p = 1;
      if (p > MAX_BUCKET_PAGES) p = MAX_BUCKET_PAGES;
      return p * PAGE_HW;
   endfunction

   function automatic logic [15:0] img_rd(int unsigned b, int unsigned off);
      int unsigned i;
      i = b * bucket_len() + off;
      if (b >= MAX_BUCKETS || i >= STORE_DEPTH) return 16'hFFFF;
      return flash_img[i];
   endfunction

   function automatic void img_wr(int unsigned b, int unsigned off, logic [15:0] v);
      int unsigned i;
      i = b * bucket_len() + off;
      if (b < MAX_BUCKETS && i < STORE_DEPTH) flash_img[i] = v;
   endfunction

   function automatic int unsigned record_hw(logic [15:0] h);
      return 1 + (int'(h[7:0]) + 1) / 2 + (int'(h[15:8]) + 1) / 2;
   endfunction

   function automatic logic [63:0] mask_bytes(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic logic [63:0] fetch_bytes(int unsigned b, int unsigned off, int unsigned n);
      logic [63:0] v;
      logic [15:0] w;
      v = '0;
      if (n > 8) n = 8;
      for (int unsigned i = 0; i < n; i++) begin
         w = img_rd(b, off + i / 2);
         v[8*i +: 8] = i[0] ? w[15:8] : w[7:0];
      end
      return v;
   endfunction

   function automatic void store_bytes(int unsigned b, int unsigned off, int unsigned n,
                                       logic [63:0] v);
      for (int unsigned i = 0; i < (n + 1) / 2 && i < 4; i++)
         img_wr(b, off + i, v[16*i +: 16]);
   endfunction

   function automatic bit same_key(int unsigned b, int unsigned off, int unsigned k,
                                   logic [63:0] key);
      logic [15:0] h;
      h = img_rd(b, off);
      return int'(h[7:0]) == k && fetch_bytes(b, off + 1, k) == key;
   endfunction

   function automatic void erase_all();
      foreach (flash_img[i]) flash_img[i] = 16'hFFFF;
      act_bkt = 0;
      log_top = bucket_len();
   endfunction

   // Move the newest record of every other key into the next bucket of the ring.
   function automatic void compact_log(int unsigned k, logic [63:0] key);
      int unsigned blen, nb, src, dtop, len, kk, off;
      logic [15:0] h;
      logic [63:0] kv;
      bit dup;
      blen = bucket_len();
      nb = act_bkt + 1;
      if (nb >= ring_size()) nb = 0;
      src = log_top;
      dtop = blen;
      while (src < blen) begin
         h = img_rd(act_bkt, src);
         len = record_hw(h);
         kk = h[7:0];
         kv = fetch_bytes(act_bkt, src + 1, kk);
         if (!(kk == k && kv == key)) begin
            dup = 1'b0;
            for (off = dtop; off < blen; off += record_hw(img_rd(nb, off)))
               if (same_key(nb, off, kk, kv)) begin
                  dup = 1'b1;
                  break;
               end
            if (!dup && dtop >= HDR_HW + len) begin
               dtop -= len;
               for (int unsigned i = 0; i < len; i++)
                  img_wr(nb, dtop + i, img_rd(act_bkt, src + i));
            end
         end
         src += len;
      end
      for (off = 0; off < blen; off++) img_wr(act_bkt, off, 16'hFFFF);
      act_bkt = nb;
      log_top = dtop;
   endfunction

   // Apply one item to the shadow store and return the result it must give.
   function automatic fkv_rsp_type apply_item(fkv_req_type r);
      fkv_rsp_type o;
      int unsigned k, dsz, d, need, blen, off, pos, kk, sd;
      logic [63:0] key, kv;
      logic [15:0] h;
      bit ok, found, dup;
      o = '0;
      blen = bucket_len();
      k = r.key_size;
      if (k < 1) k = 1;
      if (k > MAX_KEY_BYTES) k = MAX_KEY_BYTES;
      key = r.key & mask_bytes(k);
      dsz = r.data_size;
      o.status = ST_OK;
      case (r.action)
         ACT_FORMAT: begin
            erase_all();
         end
         ACT_WRITE: begin
            d = dsz > MAX_DATA_BYTES ? MAX_DATA_BYTES : dsz;
            need = 1 + (k + 1) / 2 + (d + 1) / 2;
            if (log_top < HDR_HW + need) compact_log(k, key);
            if (log_top < HDR_HW + need) begin
               o.status = ST_FULL;
            end else begin
               log_top -= need;
               img_wr(act_bkt, log_top, 16'((d << 8) | k));
               store_bytes(act_bkt, log_top + 1, k, key);
               store_bytes(act_bkt, log_top + 1 + (k + 1) / 2, d, r.data & mask_bytes(d));
            end
         end
         ACT_READ: begin
            o.status = ST_MISS;
            for (off = log_top; off < blen; off += record_hw(img_rd(act_bkt, off))) begin
               if (same_key(act_bkt, off, k, key)) begin
                  sd = img_rd(act_bkt, off) >> 8;
                  o.out_data_size = 4'(sd);
                  if (dsz < sd) begin
                     o.status = ST_SMALL;
                  end else begin
                     o.status = ST_OK;
                     o.out_data = fetch_bytes(act_bkt, off + 1 + (k + 1) / 2, sd);
                  end
                  break;
               end
            end
         end
         default: begin
            pos = log_top;
            ok = 1'b1;
            found = 1'b0;
            if (r.handle_valid) begin
               ok = 1'b0;
               for (off = log_top; off < blen; off += record_hw(img_rd(act_bkt, off)))
                  if (off == r.handle) begin
                     ok = 1'b1;
                     break;
                  end
               if (ok) pos = r.handle + record_hw(img_rd(act_bkt, r.handle));
            end
            while (ok && pos < blen) begin
               h = img_rd(act_bkt, pos);
               kk = h[7:0];
               kv = fetch_bytes(act_bkt, pos + 1, kk);
               dup = 1'b0;
               for (off = log_top; off < pos; off += record_hw(img_rd(act_bkt, off)))
                  if (same_key(act_bkt, off, kk, kv)) begin
                     dup = 1'b1;
                     break;
                  end
               if (!dup) begin
                  found = 1'b1;
                  o.out_key = kv;
                  o.out_key_size = 4'(kk);
                  o.out_data_size = h[11:8];
                  o.out_data = fetch_bytes(act_bkt, pos + 1 + (kk + 1) / 2, h[15:8]);
                  o.next_handle = 10'(pos);
                  break;
               end
               pos += record_hw(h);
            end
            if (!found) begin
               o.status = ST_MISS;
               o.at_end = 1'b1;
            end
         end
      endcase
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Result checker: every accepted result is matched against the oldest
   // expectation in the queue.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      fkv_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.out_key !== want.out_key) begin
               $error("out_key: expected %h, got %h", want.out_key, rsp_data.out_key);
               fail_count++;
            end
            if (rsp_data.out_key_size !== want.out_key_size) begin
               $error("out_key_size: expected %0d, got %0d", want.out_key_size,
                      rsp_data.out_key_size);
               fail_count++;
            end
            if (rsp_data.out_data !== want.out_data) begin
               $error("out_data: expected %h, got %h", want.out_data, rsp_data.out_data);
               fail_count++;
            end
            if (rsp_data.out_data_size !== want.out_data_size) begin
               $error("out_data_size: expected %0d, got %0d", want.out_data_size,
                      rsp_data.out_data_size);
               fail_count++;
            end
            if (rsp_data.next_handle !== want.next_handle) begin
               $error("next_handle: expected %0d, got %0d", want.next_handle,
                      rsp_data.next_handle);
               fail_count++;
            end
            if (rsp_data.at_end !== want.at_end) begin
               $error("at_end: expected %0d, got %0d", want.at_end, rsp_data.at_end);
               fail_count++;
            end
         end
      end
   end

   // Receiver back-pressure: a 16-bit stall pattern, replayed bit by bit and redrawn from a tick counter.
   // One redraw in four is all zeros, so there are stretches with no stall at all.
   logic [15:0] stall_pattern = '0;
   int unsigned stall_tick = 0;
   always @(negedge clock) begin
      if (stall_tick % 64 == 0)
         stall_pattern <= ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
      rsp_stall <= stall_pattern[stall_tick % 16];
      stall_tick <= stall_tick + 1;
   end

   // ------------------------------------------------------------------
   // Sender. Items go out in bursts; between bursts the valid line drops
   // for a random pause.
   // ------------------------------------------------------------------
   int unsigned burst_left;

   task automatic send_item(input fkv_req_type r, input bit typed, input fkv_rsp_type typed_rsp);
      fkv_rsp_type model_rsp;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      model_rsp = apply_item(r);
      if (r.action == ACT_NEXT && !model_rsp.at_end) last_handle = model_rsp.next_handle;
      pending_rsp.push_back(typed ? typed_rsp : model_rsp);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(6)) @(negedge clock);
         burst_left = $urandom_range(12);
      end else begin
         burst_left--;
      end
   endtask

   // Hold the sender until every expected result has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle. Writing either register
   // reformats the store.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == REG_BUCKET_COUNT) cfg_count = value[2:0];
      else cfg_pages = value[1:0];
      erase_all();
   endtask

   // ------------------------------------------------------------------
   // Directed table. Rows with a typed result are checked against it; the
   // others go through the shadow store.
   // ------------------------------------------------------------------
   typedef struct {
      fkv_req_type req;
      bit          typed;
      fkv_rsp_type rsp;
   } dir_row_type;

   function automatic fkv_req_type mk_req(logic [1:0] a, logic [63:0] k, logic [3:0] ks,
                                          logic [63:0] d, logic [3:0] ds,
                                          logic [9:0] hnd, logic hv);
      fkv_req_type r;
      r.action = a;
      r.key = k;
      r.key_size = ks;
      r.data = d;
      r.data_size = ds;
      r.handle = hnd;
      r.handle_valid = hv;
      return r;
   endfunction

   function automatic fkv_rsp_type mk_rsp(logic [1:0] s, logic [3:0] ds, logic e);
      fkv_rsp_type o;
      o = '0;
      o.status = s;
      o.out_data_size = ds;
      o.at_end = e;
      return o;
   endfunction

   // Random item drawn from the key pool of the current phase.
   function automatic fkv_req_type rand_item(int unsigned pool);
      fkv_req_type r;
      logic [159:0] noise;
      int unsigned sel, idx;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(fkv_req_type)-1:0];
      idx = $urandom_range(pool - 1);
      r.key = key_pool[idx];
      r.key_size = key_len_pool[idx];
      // Now and then the key size takes any encoding, out-of-range ones included.
      if ($urandom_range(9) == 0) r.key_size = 4'($urandom);
      // Upper key bytes beyond the size must be ignored by the block.
      if ($urandom_range(3) == 0) r.key = r.key | ({$urandom, $urandom} & ~mask_bytes(r.key_size));
      sel = $urandom_range(99);
      if (sel < 2) begin
         r.action = ACT_FORMAT;
      end else if (sel < 45) begin
         r.action = ACT_WRITE;
         r.data_size = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(8));
      end else if (sel < 78) begin
         r.action = ACT_READ;
         r.data_size = 4'($urandom);
      end else begin
         r.action = ACT_NEXT;
         // Mostly follow the iteration; sometimes restart or pass a stray handle.
         case ($urandom_range(3))
            0: r.handle_valid = 1'b0;
            1: r.handle_valid = 1'b1;
            default: begin
               r.handle_valid = 1'b1;
               r.handle = last_handle;
            end
         endcase
      end
      return r;
   endfunction

   initial begin
      dir_row_type dir_rows[$];
      fkv_rsp_type none;
      int unsigned phase_count [5] = '{2, 4, 0, 7, 3};
      int unsigned phase_pages [5] = '{1, 2, 0, 3, 1};
      int unsigned phase_items [5] = '{60, 60, 80, 50, 50};
      int unsigned phase_pool  [5] = '{8, 12, 70, 6, 20};

      none = '0;
      fail_count = 0;
      last_handle = '0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_count = 2;
      cfg_pages = 1;
      erase_all();
      for (int i = 0; i < KEY_POOL; i++) begin
         key_pool[i] = {$urandom, $urandom};
         key_len_pool[i] = 4'($urandom_range(1, 8));
      end

      // Reads and iteration on an empty log, then the size extremes.
      dir_rows.push_back('{mk_req(ACT_READ, 64'h5A, 4'd1, '0, 4'd8, '0, 1'b0), 1'b1,
                           mk_rsp(ST_MISS, 4'd0, 1'b0)});
      dir_rows.push_back('{mk_req(ACT_NEXT, '0, 4'd1, '0, 4'd0, '0, 1'b0), 1'b1,
                           mk_rsp(ST_MISS, 4'd0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_WRITE, '1, 4'd8, '1, 4'd8, '0, 1'b0), 1'b1,
                           mk_rsp(ST_OK, 4'd0, 1'b0)});
      dir_rows.push_back('{mk_req(ACT_WRITE, 64'h00, 4'd0, '0, 4'd0, '0, 1'b0), 1'b1,
                           mk_rsp(ST_OK, 4'd0, 1'b0)});
      dir_rows.push_back('{mk_req(ACT_WRITE, 64'h0123456789ABCDEF, 4'd15,
                           64'hFEDCBA9876543210, 4'd15, 10'h3FF, 1'b1), 1'b1,
                           mk_rsp(ST_OK, 4'd0, 1'b0)});
      // Buffer one byte too small for an eight-byte value.
      dir_rows.push_back('{mk_req(ACT_READ, '1, 4'd8, '0, 4'd7, '0, 1'b0), 1'b1,
                           mk_rsp(ST_SMALL, 4'd8, 1'b0)});
      dir_rows.push_back('{mk_req(ACT_READ, '1, 4'd8, '0, 4'd15, '0, 1'b0), 1'b0, none});
      dir_rows.push_back('{mk_req(ACT_READ, 64'hFF00, 4'd0, '0, 4'd0, '0, 1'b0), 1'b0,
                           none});
      dir_rows.push_back('{mk_req(ACT_READ, 64'h0123456789ABCDEF, 4'd8, '0, 4'd8, '0, 1'b0),
                           1'b0, none});
      // Overwrite a key and read back the newest value.
      dir_rows.push_back('{mk_req(ACT_WRITE, '1, 4'd8, 64'h1122, 4'd2, '0, 1'b0), 1'b0,
                           none});
      dir_rows.push_back('{mk_req(ACT_READ, '1, 4'd8, '0, 4'd2, '0, 1'b0), 1'b0, none});
      dir_rows.push_back('{mk_req(ACT_NEXT, '0, 4'd1, '0, 4'd0, '0, 1'b0), 1'b0, none});
      // A handle that does not start a record ends the iteration.
      dir_rows.push_back('{mk_req(ACT_NEXT, '0, 4'd1, '0, 4'd0, 10'd1, 1'b1), 1'b1,
                           mk_rsp(ST_MISS, 4'd0, 1'b1)});
      dir_rows.push_back('{mk_req(ACT_FORMAT, '1, 4'd15, '1, 4'd15, 10'h3FF, 1'b1), 1'b1,
                           mk_rsp(ST_OK, 4'd0, 1'b0)});
      dir_rows.push_back('{mk_req(ACT_READ, '1, 4'd8, '0, 4'd8, '0, 1'b0), 1'b1,
                           mk_rsp(ST_MISS, 4'd0, 1'b0)});
      dir_rows.push_back('{mk_req(ACT_NEXT, '0, 4'd1, '0, 4'd0, 10'h3FF, 1'b1), 1'b1,
                           mk_rsp(ST_MISS, 4'd0, 1'b1)});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      wait_idle();

      // Random phases, each under its own ring setting. The first keeps the reset
      // setting; zero values exercise the clamp at the low end, 7 and 3 at the high end.
      for (int p = 0; p < 5; p++) begin
         if (p != 0) begin
            wait_idle();
            csr_write(REG_BUCKET_COUNT, phase_count[p]);
            csr_write(REG_BUCKET_PAGES, phase_pages[p]);
            last_handle = '0;
         end
         for (int n = 0; n < phase_items[p]; n++) begin
            // Midway through each phase the sender waits for the block to drain.
            if (n == phase_items[p] / 2) wait_idle();
            send_item(rand_item(phase_pool[p]), 1'b0, none);
         end
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400ms;
      $display("FAIL");
      $finish;
   end

endmodule
